@@ design/ptnc_pkg.sv @@
package ptnc_pkg;

    localparam int FREQ_W  = 19;
    localparam int FS_W    = 7;
    localparam int NOTE_W  = 4;
    localparam int OCT_W   = 4;
    localparam int CENTS_W = 8;
    localparam int CHZ_W   = 20;

    localparam logic [1:0] REG_MIN_FREQ = 2'd0;
    localparam logic [1:0] REG_MAX_FREQ = 2'd1;
    localparam logic [1:0] REG_FULL_SCALE = 2'd2;

    localparam logic [FREQ_W-1:0] MIN_FREQ_RST = 19'd1280;
    localparam logic [FREQ_W-1:0] MAX_FREQ_RST = 19'd339200;
    localparam logic [FS_W-1:0]   FULL_SCALE_RST = 7'd50;

    localparam logic [CHZ_W-1:0] PITCH_CHZ [12][9] = '{
        '{20'd0, 20'd3270, 20'd6541, 20'd13082, 20'd26163, 20'd52325, 20'd104650,
          20'd209300, 20'd418600},
        '{20'd0, 20'd3465, 20'd6930, 20'd13859, 20'd27718, 20'd55436, 20'd110870,
          20'd221740, 20'd443480},
        '{20'd0, 20'd3695, 20'd7391, 20'd14783, 20'd29366, 20'd58732, 20'd117460,
          20'd234920, 20'd469840},
        '{20'd0, 20'd3888, 20'd7778, 20'd15556, 20'd31113, 20'd62226, 20'd124450,
          20'd248900, 20'd497800},
        '{20'd2061, 20'd4121, 20'd8241, 20'd16481, 20'd32963, 20'd65926, 20'd131850,
          20'd263700, 20'd527400},
        '{20'd2182, 20'd4365, 20'd8731, 20'd17462, 20'd34923, 20'd69846, 20'd139690,
          20'd279380, 20'd0},
        '{20'd2312, 20'd4625, 20'd9250, 20'd18500, 20'd36999, 20'd73998, 20'd148000,
          20'd296000, 20'd0},
        '{20'd2450, 20'd4900, 20'd9800, 20'd19600, 20'd39200, 20'd78400, 20'd156800,
          20'd313600, 20'd0},
        '{20'd2595, 20'd5190, 20'd10380, 20'd20700, 20'd41530, 20'd83060, 20'd166120,
          20'd333240, 20'd0},
        '{20'd2750, 20'd5500, 20'd11000, 20'd22000, 20'd44000, 20'd88000, 20'd172000,
          20'd344000, 20'd0},
        '{20'd2913, 20'd5826, 20'd11654, 20'd23308, 20'd46616, 20'd93232, 20'd186460,
          20'd372920, 20'd0},
        '{20'd3087, 20'd6174, 20'd12348, 20'd24696, 20'd49388, 20'd98775, 20'd197550,
          20'd395100, 20'd0}
    };

endpackage

@@ design/pitch_to_note_cents_top.sv @@
// Throughput: one beat per cycle while out_ready does not stall the pipeline;
// the scan runs one note row per stage and the deviation divide one
// quotient bit per stage.
// Reset: asynchronous active-low rst_n clears valid bits and loads register
// defaults (min 1280, max 339200, full scale 50).
module pitch_to_note_cents_top #(
    parameter int OCTAVE_COUNT = 9,
    parameter int FREQ_FRAC_BITS = 6
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [1:0]                    cfg_index,
    input  logic [ptnc_pkg::FREQ_W-1:0]   cfg_data,
    input  logic                          in_valid,
    output logic                          in_ready,
    input  logic [ptnc_pkg::FREQ_W-1:0]   freq,
    output logic                          out_valid,
    input  logic                          out_ready,
    output logic                          in_range,
    output logic [ptnc_pkg::NOTE_W-1:0]   note_index,
    output logic [ptnc_pkg::OCT_W-1:0]    octave_index,
    output logic signed [ptnc_pkg::CENTS_W-1:0] cents
);
    import ptnc_pkg::*;

    localparam int OCTS   = (OCTAVE_COUNT < 9) ? OCTAVE_COUNT : 9;
    localparam int UNIT_W = 26 + FREQ_FRAC_BITS + 1;
    localparam int SCAN_N = 12;
    localparam int NUM_W  = UNIT_W + 8;
    localparam int Q_W    = 10;
    localparam int DIV_N  = Q_W;
    localparam int ST_N   = 1 + SCAN_N + 2 + DIV_N + 1;

    typedef struct packed {
        logic              ok;
        logic [UNIT_W-1:0] fs;
        logic [UNIT_W-1:0] best;
        logic              found;
        logic [3:0]        bn;
        logic [3:0]        bo;
    } scan_t;

    typedef struct packed {
        logic              ok;
        logic              below;
        logic [3:0]        bn;
        logic [3:0]        bo;
        logic [FS_W-1:0]   fsc;
        logic [NUM_W-1:0]  num;
        logic [UNIT_W-1:0] gap;
        logic [Q_W-1:0]    q;
    } div_t;

    logic [FREQ_W-1:0] min_freq_reg;
    logic [FREQ_W-1:0] max_freq_reg;
    logic [FS_W-1:0]   full_scale_reg;

    logic [ST_N-1:0] vld_reg;
    logic [ST_N-1:0] adv;

    scan_t scan_reg [SCAN_N+1];
    scan_t scan_next [SCAN_N];
    div_t  prep_reg;
    div_t  prep_next;
    div_t  mul_next;
    div_t  div_reg [DIV_N+1];
    div_t  div_next [DIV_N];
    logic              out_rng_reg;
    logic [NOTE_W-1:0] out_note_reg;
    logic [OCT_W-1:0]  out_oct_reg;
    logic [CENTS_W-1:0] out_cents_reg;
    logic [CENTS_W-1:0] cents_next;

    function automatic logic [UNIT_W-1:0] pitch_at(input int n, input int o);
        logic [UNIT_W-1:0] r;
        r = '0;
        if (n >= 0 && n < 12 && o >= 0 && o < OCTS)
            r = UNIT_W'(PITCH_CHZ[n][o]) << FREQ_FRAC_BITS;
        return r;
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_freq_reg   <= MIN_FREQ_RST;
            max_freq_reg   <= MAX_FREQ_RST;
            full_scale_reg <= FULL_SCALE_RST;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_MIN_FREQ:   min_freq_reg <= cfg_data;
                REG_MAX_FREQ:   max_freq_reg <= cfg_data;
                REG_FULL_SCALE: full_scale_reg <= cfg_data[FS_W-1:0];
                default: ;
            endcase
        end
    end

    // stall chain: a stage moves when the next one is free or moving
    always_comb
    begin
        adv[ST_N-1] = !vld_reg[ST_N-1] || out_ready;
        for (int i = ST_N-2; i >= 0; i--)
            adv[i] = !vld_reg[i] || adv[i+1];
    end
    assign in_ready = adv[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else
        begin
            if (adv[0])
                vld_reg[0] <= in_valid;
            for (int i = 1; i < ST_N; i++)
                if (adv[i])
                    vld_reg[i] <= vld_reg[i-1];
        end
    end

    // stage 0: range check and scale
    always_ff @(posedge clk)
    begin
        if (adv[0])
        begin
            scan_reg[0].ok    <= (freq >= min_freq_reg) && (freq <= max_freq_reg);
            scan_reg[0].fs    <= UNIT_W'(freq) * UNIT_W'(100);
            scan_reg[0].best  <= UNIT_W'(64'd10000000 << FREQ_FRAC_BITS);
            scan_reg[0].found <= 1'b0;
            scan_reg[0].bn    <= '0;
            scan_reg[0].bo    <= '0;
        end
    end

    // scan: one note row per stage
    for (genvar n = 0; n < SCAN_N; n++)
    begin : g_scan
        always_comb
        begin
            logic [UNIT_W-1:0] p;
            logic [UNIT_W-1:0] d;
            scan_next[n] = scan_reg[n];
            for (int o = 0; o < OCTS; o++)
            begin
                p = pitch_at(n, o);
                d = (scan_next[n].fs > p) ? scan_next[n].fs - p : p - scan_next[n].fs;
                if (p != '0 && d < scan_next[n].best)
                begin
                    scan_next[n].best  = d;
                    scan_next[n].bn    = 4'(n);
                    scan_next[n].bo    = 4'(o);
                    scan_next[n].found = 1'b1;
                end
            end
        end
        always_ff @(posedge clk)
        begin
            if (adv[n+1])
                scan_reg[n+1] <= scan_next[n];
        end
    end

    // neighbor lookup, magnitude and gap
    always_comb
    begin
        logic [UNIT_W-1:0] cur, lo, hi, mag;
        int bn, bo;
        bn = int'(scan_reg[SCAN_N].bn);
        bo = int'(scan_reg[SCAN_N].bo);
        cur = pitch_at(bn, bo);
        lo  = (bn > 0) ? pitch_at(bn-1, bo) : pitch_at(11, bo-1);
        hi  = (bn < 11) ? pitch_at(bn+1, bo) : pitch_at(0, bo+1);
        prep_next.ok    = scan_reg[SCAN_N].ok && scan_reg[SCAN_N].found;
        prep_next.bn    = scan_reg[SCAN_N].bn;
        prep_next.bo    = scan_reg[SCAN_N].bo;
        prep_next.fsc   = full_scale_reg;
        prep_next.below = scan_reg[SCAN_N].fs < cur;
        prep_next.q     = '0;
        prep_next.num   = '0;
        if (prep_next.below)
        begin
            mag = cur - scan_reg[SCAN_N].fs;
            prep_next.gap = (cur > lo) ? cur - lo : '0;
        end
        else
        begin
            mag = scan_reg[SCAN_N].fs - cur;
            if (hi == '0)
                prep_next.gap = (cur > lo) ? cur - lo : '0;
            else
                prep_next.gap = (hi > cur) ? hi - cur : '0;
        end
        prep_next.num = NUM_W'(mag);
    end

    always_ff @(posedge clk)
    begin
        if (adv[SCAN_N+1])
            prep_reg <= prep_next;
    end

    // numerator = mag * 2 * full_scale
    always_comb
    begin
        mul_next     = prep_reg;
        mul_next.num = NUM_W'(prep_reg.num[UNIT_W-1:0] * UNIT_W'(prep_reg.fsc)) << 1;
    end

    always_ff @(posedge clk)
    begin
        if (adv[SCAN_N+2])
            div_reg[0] <= mul_next;
    end

    // restoring divide, quotient capped at 2^Q_W-1 (above any full scale)
    for (genvar k = 0; k < DIV_N; k++)
    begin : g_div
        localparam int SH = DIV_N - 1 - k;
        always_comb
        begin
            logic [NUM_W+SH-1:0] trial;
            div_next[k] = div_reg[k];
            trial = (NUM_W+SH)'(div_reg[k].gap) << SH;
            if (div_reg[k].gap != '0 && (NUM_W+SH)'(div_reg[k].num) >= trial)
            begin
                div_next[k].num  = div_reg[k].num - NUM_W'(trial);
                div_next[k].q[SH] = 1'b1;
            end
        end
        always_ff @(posedge clk)
        begin
            if (adv[SCAN_N+3+k])
                div_reg[k+1] <= div_next[k];
        end
    end

    // saturation and sign; a numerator too large for the quotient saturates anyway
    always_comb
    begin
        logic [Q_W-1:0] q;
        logic           ovf;
        ovf = div_reg[DIV_N].gap != '0 &&
              div_reg[DIV_N].num >= NUM_W'(div_reg[DIV_N].gap);
        q = div_reg[DIV_N].q;
        if (div_reg[DIV_N].gap == '0)
            q = '0;
        else if (ovf || q > Q_W'(div_reg[DIV_N].fsc))
            q = Q_W'(div_reg[DIV_N].fsc);
        cents_next = div_reg[DIV_N].below ? CENTS_W'(-q) : CENTS_W'(q);
    end

    always_ff @(posedge clk)
    begin
        if (adv[ST_N-1])
        begin
            out_rng_reg   <= div_reg[DIV_N].ok;
            out_note_reg  <= div_reg[DIV_N].ok ? div_reg[DIV_N].bn : '0;
            out_oct_reg   <= div_reg[DIV_N].ok ? div_reg[DIV_N].bo : '0;
            out_cents_reg <= div_reg[DIV_N].ok ? cents_next : '0;
        end
    end

    assign out_valid    = vld_reg[ST_N-1];
    assign in_range     = out_rng_reg;
    assign note_index   = out_note_reg;
    assign octave_index = out_oct_reg;
    assign cents        = out_cents_reg;

endmodule

@@ sim/tb_pitch_to_note_cents_top.sv @@
module tb_pitch_to_note_cents_top;
    import ptnc_pkg::*;

    localparam logic [1:0] REG_UNUSED = 2'd3;
    localparam int IDLE_LIMIT = 5000;
    localparam int DRAIN_CYCLES = 60;

    typedef struct packed {
        logic                    in_range;
        logic [NOTE_W-1:0]       note;
        logic [OCT_W-1:0]        octave;
        logic [CENTS_W-1:0]      cents;
    } note_result_t;

    logic                 clk;
    logic                 rst_n;
    logic                 cfg_we;
    logic [1:0]           cfg_index;
    logic [FREQ_W-1:0]    cfg_data;
    logic                 in_valid;
    logic                 in_ready;
    logic [FREQ_W-1:0]    freq;
    logic                 out_valid;
    logic                 out_ready;
    logic                 in_range;
    logic [NOTE_W-1:0]    note_index;
    logic [OCT_W-1:0]     octave_index;
    logic signed [CENTS_W-1:0] cents;

    // mirror of the block's registers
    logic [FREQ_W-1:0]    lim_lo;
    logic [FREQ_W-1:0]    lim_hi;
    logic [FS_W-1:0]      scale;

    note_result_t         pending_notes[$];
    int                   send_idle_pct;
    int                   recv_stall_pct;
    int                   recv_hold;
    int                   quiet_cycles;
    bit                   failed;

    pitch_to_note_cents_top uut (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
        .in_valid(in_valid), .in_ready(in_ready), .freq(freq),
        .out_valid(out_valid), .out_ready(out_ready),
        .in_range(in_range), .note_index(note_index),
        .octave_index(octave_index), .cents(cents)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic longint pitch_word(int n, int o);
        if (n < 0 || n > 11 || o < 0 || o > 8)
            return 0;
        return longint'(PITCH_CHZ[n][o]) << 6;
    endfunction

    function automatic note_result_t nearest_note(logic [FREQ_W-1:0] f);
        note_result_t r;
        longint fs, best, p, d, cur, lo, hi, mag, gap, q;
        int bn, bo;
        bit found, below;
        r = '0;
        bn = 0;
        bo = 0;
        found = 0;
        if (f < lim_lo || f > lim_hi)
            return r;
        fs = longint'(f) * 100;
        best = longint'(10000000) << 6;
        for (int n = 0; n < 12; n++)
        begin
            for (int o = 0; o < 9; o++)
            begin
                p = pitch_word(n, o);
                if (p != 0)
                begin
                    d = fs > p ? fs - p : p - fs;
                    if (d < best)
                    begin
                        best = d;
                        bn = n;
                        bo = o;
                        found = 1;
                    end
                end
            end
        end
        if (!found)
            return r;
        cur = pitch_word(bn, bo);
        lo = bn > 0 ? pitch_word(bn - 1, bo) : pitch_word(11, bo - 1);
        hi = bn < 11 ? pitch_word(bn + 1, bo) : pitch_word(0, bo + 1);
        below = fs < cur;
        if (below)
        begin
            mag = cur - fs;
            gap = cur > lo ? cur - lo : 0;
        end
        else
        begin
            mag = fs - cur;
            if (hi == 0)
                gap = cur > lo ? cur - lo : 0;
            else
                gap = hi > cur ? hi - cur : 0;
        end
        if (gap == 0)
            q = 0;
        else
        begin
            q = (mag * 2 * longint'(scale)) / gap;
            if (q > longint'(scale))
                q = scale;
        end
        r.in_range = 1'b1;
        r.note = bn[NOTE_W-1:0];
        r.octave = bo[OCT_W-1:0];
        r.cents = below ? 8'(-q) : 8'(q);
        return r;
    endfunction

    // receiver side
    always @(posedge clk)
    begin
        if (recv_hold > 0)
        begin
            out_ready <= 1'b0;
            recv_hold <= recv_hold - 1;
        end
        else
            out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // prediction at input beat, comparison at output beat
    always @(posedge clk)
    begin
        note_result_t exp_r;
        if (rst_n)
        begin
            if (in_valid && in_ready)
                pending_notes.push_back(nearest_note(freq));
            if (out_valid && out_ready)
            begin
                if (pending_notes.size() == 0)
                begin
                    $display("%0t: unexpected result beat %0b %0d %0d %0d", $time,
                             in_range, note_index, octave_index, cents);
                    failed = 1;
                end
                else
                begin
                    exp_r = pending_notes.pop_front();
                    if (exp_r.in_range !== in_range || exp_r.note !== note_index ||
                        exp_r.octave !== octave_index || exp_r.cents !== cents)
                    begin
                        $display("%0t: expected rng %0b note %0d oct %0d cents %0d, got %0b %0d %0d %0d",
                                 $time, exp_r.in_range, exp_r.note, exp_r.octave,
                                 $signed(exp_r.cents), in_range, note_index,
                                 octave_index, cents);
                        failed = 1;
                    end
                end
            end
            if ((in_valid && in_ready) || (out_valid && out_ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= IDLE_LIMIT)
            begin
                $display("status: fail");
                $finish;
            end
        end
    end

    task automatic send_freq(logic [FREQ_W-1:0] f);
        int gap;
        gap = 0;
        while ($urandom_range(99) < send_idle_pct && gap < 40)
            gap++;
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        freq <= f;
        @(posedge clk);
        while (!in_ready)
            @(posedge clk);
    endtask

    task automatic wait_idle();
        in_valid <= 1'b0;
        @(posedge clk);
        while (pending_notes.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(logic [1:0] idx, logic [FREQ_W-1:0] val);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        @(posedge clk);
        cfg_we <= 1'b0;
        case (idx)
            REG_MIN_FREQ: lim_lo = val;
            REG_MAX_FREQ: lim_hi = val;
            REG_FULL_SCALE: scale = val[FS_W-1:0];
            default: ;
        endcase
        @(posedge clk);
    endtask

    function automatic logic [FREQ_W-1:0] rand_freq();
        case ($urandom_range(3))
            0: return FREQ_W'($urandom);
            1: return FREQ_W'($urandom_range(1280, 40000));
            default: return FREQ_W'($urandom_range(1000, 340000));
        endcase
    endfunction

    task automatic test_directed();
        logic [FREQ_W-1:0] pts[$];
        pts = '{19'd0, 19'd1279, 19'd1280, 19'd1319, 19'd2093, 19'd28160,
                19'd339200, 19'd339201, 19'd524287};
        foreach (pts[i]) send_freq(pts[i]);
        wait_idle();
        write_reg(REG_MIN_FREQ, 19'd0);
        write_reg(REG_MAX_FREQ, 19'h7FFFF);
        pts = '{19'd0, 19'd1, 19'd1319, 19'd1300, 19'd2000, 19'd3951, 19'd2107,
                19'd337536, 19'd524287, 19'd252877, 19'd110080, 19'd267904};
        foreach (pts[i]) send_freq(pts[i]);
        wait_idle();
    endtask

    task automatic test_config();
        logic [FS_W-1:0] scales[$];
        scales = '{7'd1, 7'd100, 7'd0, 7'd127};
        write_reg(REG_UNUSED, 19'h7FFFF);
        foreach (scales[i])
        begin
            write_reg(REG_FULL_SCALE, {12'd0, scales[i]});
            repeat (20) send_freq(rand_freq());
            wait_idle();
        end
        write_reg(REG_MIN_FREQ, 19'd200000);
        write_reg(REG_MAX_FREQ, 19'd100000);
        repeat (20) send_freq(rand_freq());
        wait_idle();
        write_reg(REG_MIN_FREQ, 19'h7FFFF);
        write_reg(REG_MAX_FREQ, 19'h7FFFF);
        send_freq(19'h7FFFF);
        send_freq(19'h7FFFE);
        wait_idle();
    endtask

    task automatic test_random();
        int idle_mode[4][2] = '{'{0, 0}, '{70, 0}, '{0, 70}, '{30, 30}};
        for (int ph = 0; ph < 4; ph++)
        begin
            write_reg(REG_MIN_FREQ, FREQ_W'(ph == 0 ? 0 : $urandom_range(0, 3000)));
            write_reg(REG_MAX_FREQ,
                      FREQ_W'(ph == 0 ? 19'h7FFFF : $urandom_range(300000, 524287)));
            write_reg(REG_FULL_SCALE, FREQ_W'($urandom_range(1, 100)));
            send_idle_pct = idle_mode[ph][0];
            recv_stall_pct = idle_mode[ph][1];
            repeat (110) send_freq(rand_freq());
            wait_idle();
        end
        send_idle_pct = 0;
        recv_stall_pct = 0;
    endtask

    task automatic test_backpressure();
        write_reg(REG_FULL_SCALE, 19'd50);
        recv_hold <= 400;
        repeat (80) send_freq(rand_freq());
        wait_idle();
        recv_stall_pct = 20;
        repeat (20) send_freq(rand_freq());
        wait_idle();
        recv_stall_pct = 0;
    endtask

    initial
    begin
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = REG_MIN_FREQ;
        cfg_data = '0;
        in_valid = 1'b0;
        freq = '0;
        out_ready = 1'b0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        recv_hold = 0;
        quiet_cycles = 0;
        failed = 0;
        lim_lo = MIN_FREQ_RST;
        lim_hi = MAX_FREQ_RST;
        scale = FULL_SCALE_RST;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_config();
        test_random();
        test_backpressure();
        if (!failed)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
